### hw/rtl/hufd_pkg.sv
package hufd_pkg;

  localparam int unsigned MAX_NODES   = 512;
  localparam int unsigned STACK_DEPTH = 256;

  // Address widths index the memories; count widths also hold the full depth.
  localparam int unsigned NODE_AW = $clog2(MAX_NODES);
  localparam int unsigned NODE_CW = $clog2(MAX_NODES + 1);
  localparam int unsigned STK_AW  = $clog2(STACK_DEPTH);
  localparam int unsigned STK_CW  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LEAF   = 2'd0,
    OP_JOIN   = 2'd1,
    OP_FINISH = 2'd2,
    OP_DECODE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISSING    = 2'd1,
    ST_FAULT      = 2'd2,
    ST_NOT_LOADED = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] leaf_byte;
    logic       code_bit;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    status_t    status;
  } out_t;

  typedef struct packed {
    logic               is_internal;
    logic [7:0]         byte_val;
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
  } node_t;

endpackage

### hw/rtl/hufd_ram.sv
module hufd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/huffman_tree_bit_decoder.sv
// A leaf, finish or rejected word goes straight to S_EMIT; a join passes through
// S_JR and S_JL, and a decode bit through S_DCUR and S_DNXT (S_DNXT skipped on a missing child).
// One word is in work at a time and the next is taken in the cycle the result
// is presented. S_EMIT waits while an earlier result is still stalled at the
// output register.
// Reset (rst_n low, synchronous) empties the counts and clears the loaded flag.
module huffman_tree_bit_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hufd_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hufd_pkg::out_t out_data
);

  import hufd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_JR   = 6'b000010,
    S_JL   = 6'b000100,
    S_DCUR = 6'b001000,
    S_DNXT = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [STK_CW-1:0]  stack_count_r, stack_count_nxt;
  logic [NODE_CW-1:0] node_count_r, node_count_nxt;
  logic [NODE_AW-1:0] root_r, root_nxt;
  logic [NODE_AW-1:0] cursor_r, cursor_nxt;
  logic               ready_r, ready_nxt;
  logic               code_bit_r, code_bit_nxt;
  logic [NODE_AW-1:0] right_r, right_nxt;
  logic [NODE_AW-1:0] next_r, next_nxt;
  out_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               node_we;
  logic [NODE_AW-1:0] node_waddr, node_raddr;
  node_t              node_wdata, node_rd;
  logic               stk_we;
  logic [STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [NODE_AW-1:0] stk_wdata, stk_rd;
  logic [NODE_AW-1:0] next_idx;
  logic [STK_CW-1:0]  sc_m1, sc_m2;

  assign in_stall = (state_r != S_IDLE);
  assign sc_m1    = stack_count_r - STK_CW'(1);
  assign sc_m2    = stack_count_r - STK_CW'(2);
  assign next_idx = code_bit_r ? node_rd.right : node_rd.left;

  hufd_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (node_waddr),
    .wr_data (node_wdata),
    .rd_addr (node_raddr),
    .rd_data (node_rd)
  );

  hufd_ram #(.WIDTH(NODE_AW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rd)
  );

  always_comb begin
    state_nxt       = state_r;
    stack_count_nxt = stack_count_r;
    node_count_nxt  = node_count_r;
    root_nxt        = root_r;
    cursor_nxt      = cursor_r;
    ready_nxt       = ready_r;
    code_bit_nxt    = code_bit_r;
    right_nxt       = right_r;
    next_nxt        = next_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;

    node_we    = 1'b0;
    node_waddr = node_count_r[NODE_AW-1:0];
    node_wdata = '{is_internal: 1'b0, byte_val: in_data.leaf_byte,
                   left: '0, right: '0};
    node_raddr = cursor_r;
    stk_we     = 1'b0;
    stk_waddr  = stack_count_r[STK_AW-1:0];
    stk_wdata  = node_count_r[NODE_AW-1:0];
    stk_raddr  = sc_m1[STK_AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          code_bit_nxt = in_data.code_bit;
          res_nxt      = '{byte_out: 8'd0, byte_valid: 1'b0, status: ST_OK};
          state_nxt    = S_EMIT;
          if (in_data.op != OP_DECODE && ready_r) begin
            res_nxt.status = ST_FAULT;
          end else begin
            unique case (in_data.op)
              OP_LEAF: begin
                if (node_count_r >= NODE_CW'(MAX_NODES) ||
                    stack_count_r >= STK_CW'(STACK_DEPTH)) begin
                  res_nxt.status = ST_FAULT;
                end else begin
                  node_we         = 1'b1;
                  stk_we          = 1'b1;
                  stack_count_nxt = stack_count_r + STK_CW'(1);
                  node_count_nxt  = node_count_r + NODE_CW'(1);
                end
              end
              OP_JOIN: begin
                if (node_count_r >= NODE_CW'(MAX_NODES) ||
                    stack_count_r < STK_CW'(2)) begin
                  res_nxt.status = ST_FAULT;
                end else begin
                  // Right child address goes out now; left follows next cycle.
                  state_nxt = S_JR;
                end
              end
              OP_FINISH: begin
                if (node_count_r == '0) begin
                  res_nxt.status = ST_FAULT;
                end else begin
                  root_nxt   = NODE_AW'(node_count_r - NODE_CW'(1));
                  cursor_nxt = NODE_AW'(node_count_r - NODE_CW'(1));
                  ready_nxt  = 1'b1;
                end
              end
              OP_DECODE: begin
                if (!ready_r) begin
                  res_nxt.status = ST_NOT_LOADED;
                end else begin
                  state_nxt = S_DCUR;
                end
              end
              default: res_nxt.status = ST_FAULT;
            endcase
          end
        end
      end
      S_JR: begin
        right_nxt = stk_rd;
        stk_raddr = sc_m2[STK_AW-1:0];
        state_nxt = S_JL;
      end
      S_JL: begin
        node_we         = 1'b1;
        node_wdata      = '{is_internal: 1'b1, byte_val: 8'd0,
                            left: stk_rd, right: right_r};
        stk_we          = 1'b1;
        stk_waddr       = sc_m2[STK_AW-1:0];
        stack_count_nxt = sc_m1;
        node_count_nxt  = node_count_r + NODE_CW'(1);
        state_nxt       = S_EMIT;
      end
      S_DCUR: begin
        if (!node_rd.is_internal) begin
          res_nxt.status = ST_MISSING;
          state_nxt      = S_EMIT;
        end else begin
          next_nxt   = next_idx;
          node_raddr = next_idx;
          state_nxt  = S_DNXT;
        end
      end
      S_DNXT: begin
        if (node_rd.is_internal) begin
          cursor_nxt = next_r;
        end else begin
          cursor_nxt         = root_r;
          res_nxt.byte_out   = node_rd.byte_val;
          res_nxt.byte_valid = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      stack_count_r <= '0;
      node_count_r  <= '0;
      root_r        <= '0;
      cursor_r      <= '0;
      ready_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      stack_count_r <= stack_count_nxt;
      node_count_r  <= node_count_nxt;
      root_r        <= root_nxt;
      cursor_r      <= cursor_nxt;
      ready_r       <= ready_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_bit_r <= code_bit_nxt;
    right_r    <= right_nxt;
    next_r     <= next_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_count_r <= STK_CW'(STACK_DEPTH))
    else $error("build stack count exceeds its depth");

  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    node_count_r <= NODE_CW'(MAX_NODES))
    else $error("node count exceeds the store size");

  a_cursor_stored: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (NODE_CW'(cursor_r) < node_count_r && NODE_CW'(root_r) < node_count_r))
    else $error("cursor or root points past the stored nodes");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.byte_valid) |-> (out_data.status == ST_OK))
    else $error("decoded byte reported with a fault status");

endmodule

### bench/huffman_tree_bit_decoder_checker.sv
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  hufd_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  hufd_pkg::out_t out_data,
  output int             fail_count,
  output int             pending
);

  import hufd_pkg::*;

  node_t              node_mem [MAX_NODES];
  logic [NODE_AW-1:0] build_mem [STACK_DEPTH];
  logic [STK_CW-1:0]  stack_cnt;
  logic [NODE_CW-1:0] node_cnt;
  logic [NODE_AW-1:0] root_idx;
  logic [NODE_AW-1:0] cursor_idx;
  logic               tree_loaded;
  out_t               expected_q [$];

  // Applies one input word to the tree model and returns the result it must give.
  function automatic out_t walk_tree(in_t w);
    out_t               r;
    node_t              nd;
    logic [NODE_AW-1:0] nxt;
    logic [STK_CW-1:0]  top_i;
    r = '0;
    r.status = ST_OK;
    if (w.op != OP_DECODE && tree_loaded) begin
      r.status = ST_FAULT;
    end else begin
      case (w.op)
        OP_LEAF: begin
          if (node_cnt >= MAX_NODES || stack_cnt >= STACK_DEPTH) begin
            r.status = ST_FAULT;
          end else begin
            nd = '0;
            nd.byte_val = w.leaf_byte;
            node_mem[node_cnt[NODE_AW-1:0]] = nd;
            build_mem[stack_cnt[STK_AW-1:0]] = node_cnt[NODE_AW-1:0];
            stack_cnt++;
            node_cnt++;
          end
        end
        OP_JOIN: begin
          if (node_cnt >= MAX_NODES || stack_cnt < 2) begin
            r.status = ST_FAULT;
          end else begin
            nd = '0;
            nd.is_internal = 1'b1;
            top_i = stack_cnt - 1'b1;
            nd.right = build_mem[top_i[STK_AW-1:0]];
            top_i = stack_cnt - 2'd2;
            nd.left = build_mem[top_i[STK_AW-1:0]];
            node_mem[node_cnt[NODE_AW-1:0]] = nd;
            build_mem[top_i[STK_AW-1:0]] = node_cnt[NODE_AW-1:0];
            stack_cnt--;
            node_cnt++;
          end
        end
        OP_FINISH: begin
          if (node_cnt == 0) begin
            r.status = ST_FAULT;
          end else begin
            root_idx = node_cnt[NODE_AW-1:0] - 1'b1;
            cursor_idx = root_idx;
            tree_loaded = 1'b1;
          end
        end
        OP_DECODE: begin
          if (!tree_loaded) begin
            r.status = ST_NOT_LOADED;
          end else if (!node_mem[cursor_idx].is_internal) begin
            r.status = ST_MISSING;
          end else begin
            nxt = w.code_bit ? node_mem[cursor_idx].right : node_mem[cursor_idx].left;
            if (node_mem[nxt].is_internal) begin
              cursor_idx = nxt;
            end else begin
              // A leaf ends the code: emit its byte and restart at the root.
              cursor_idx = root_idx;
              r.byte_out = node_mem[nxt].byte_val;
              r.byte_valid = 1'b1;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic void report(string field, int want, int got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      stack_cnt = '0;
      node_cnt = '0;
      root_idx = '0;
      cursor_idx = '0;
      tree_loaded = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: extra result, expected none, got byte %0d valid %0b status %0d",
                   $time, out_data.byte_out, out_data.byte_valid, out_data.status);
        end else begin
          want = expected_q.pop_front();
          if (out_data.byte_out !== want.byte_out) begin
            report("byte_out", want.byte_out, out_data.byte_out);
          end
          if (out_data.byte_valid !== want.byte_valid) begin
            report("byte_valid", want.byte_valid, out_data.byte_valid);
          end
          if (out_data.status !== want.status) begin
            report("status", want.status, out_data.status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(walk_tree(in_data));
      end
    end
    pending = expected_q.size();
  end

endmodule

### bench/huffman_tree_bit_decoder_test.sv
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_test;
  import hufd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int JOIN_WORDS   = 24;
  localparam int DECODE_WORDS = 110;
  localparam int QUIET_WORDS  = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int fail_count;
  int pending;
  int accepted;
  int cycles;
  bit quiet;
  bit long_done;

  // Load bookkeeping, used only to steer the stimulus toward well-formed trees.
  int stacked;
  int nodes;
  bit finished;

  always #10 clk = ~clk;

  huffman_tree_bit_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  huffman_tree_bit_decoder_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(op_t op, logic [7:0] b, logic c);
    in_t w;
    w.op = op;
    w.leaf_byte = b;
    w.code_bit = c;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    accepted++;
    case (op)
      OP_LEAF: begin
        if (!finished && nodes < MAX_NODES && stacked < STACK_DEPTH) begin
          nodes++;
          stacked++;
        end
      end
      OP_JOIN: begin
        if (!finished && nodes < MAX_NODES && stacked >= 2) begin
          nodes++;
          stacked--;
        end
      end
      OP_FINISH: begin
        if (nodes > 0) begin
          finished = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_rand(op_t op);
    send_word(op, 8'($urandom), 1'($urandom));
  endtask

  // Result side: random stall bursts, and one long hold so the block backs up.
  initial begin
    int stretch;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && !long_done && accepted >= 40) begin
        long_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        stretch = ($urandom_range(0, 5) == 0) ? 40 : 8;
        out_stall <= 1'b0;
        repeat ($urandom_range(1, stretch)) @(posedge clk);
      end
    end
  end

  initial begin
    int k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty block: decoding, joining and finishing must all be refused; then joins on one and two leaves.
    send_word(OP_DECODE, 8'h00, 1'b0);
    send_word(OP_DECODE, 8'hFF, 1'b1);
    send_rand(OP_JOIN);
    send_rand(OP_FINISH);
    send_word(OP_LEAF, 8'h00, 1'b1);
    send_rand(OP_JOIN);
    send_word(OP_LEAF, 8'hFF, 1'b0);
    send_rand(OP_JOIN);
    send_word(OP_LEAF, 8'hA5, 1'b0);
    send_word(OP_LEAF, 8'h5A, 1'b1);
    send_rand(OP_DECODE);

    // Grow mostly leaves with a few joins and decodes until the build stack is full.
    while (stacked < STACK_DEPTH) begin
      if ($urandom_range(0, 19) == 0) begin
        send_rand(OP_DECODE);
      end else if (stacked >= 2 && $urandom_range(0, 19) == 0) begin
        send_rand(OP_JOIN);
      end else begin
        send_rand(OP_LEAF);
      end
    end
    send_rand(OP_LEAF);

    // Combine the top of the stack; the last load word is a join so the root is internal.
    repeat (JOIN_WORDS) send_rand(OP_JOIN);
    send_rand(OP_FINISH);
    send_rand(OP_LEAF);
    send_rand(OP_JOIN);
    send_rand(OP_FINISH);

    for (k = 0; k < DECODE_WORDS; k++) begin
      if (k >= DECODE_WORDS - QUIET_WORDS) begin
        quiet = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_rand(op_t'($urandom_range(0, 2)));
      end else begin
        send_rand(OP_DECODE);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/hufd_pkg.sv
hw/rtl/hufd_ram.sv
hw/rtl/huffman_tree_bit_decoder.sv
bench/huffman_tree_bit_decoder_checker.sv
bench/huffman_tree_bit_decoder_test.sv
